// ===== src/dfts_pkg.sv =====
// shared types and constants for the decimal number text scanner
// no dependencies; imported by decimal_float_text_scanner_top and tb
`default_nettype none

package dfts_pkg;

    localparam int POS_BITS_DEFAULT = 16;

    localparam logic [7:0] RADIX_RESET = 8'h2E;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LOW_E = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LOW_D = 8'h64;
    localparam logic [7:0] CH_UP_D  = 8'h44;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // largest mantissa that still takes one more digit (up to 5 at the limit)
    localparam logic [63:0] MANT_LIMIT = 64'd1844674407370955161;
    localparam logic [3:0]  MANT_LAST_DIGIT = 4'd5;

    localparam logic signed [31:0] EXP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] EXP_MIN = 32'sh8000_0000;
    localparam logic [30:0]        EXP_DIGITS_MAX = 31'h7FFF_FFFF;

    localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_WS,
        PH_INT,
        PH_INT_SKIP,
        PH_FRAC,
        PH_FRAC_SKIP,
        PH_EXP_LETTER,
        PH_EXP_SIGNED,
        PH_EXP_DIGITS
    } phase_t;

    typedef struct packed {
        logic [7:0] character;
        logic       first;
    } scan_in_t;

    typedef struct packed {
        logic               negative;
        logic [63:0]        mantissa;
        logic signed [31:0] exponent;
        logic [15:0]        end_offset;
        logic               no_conversion;
    } scan_out_t;

endpackage

`default_nettype wire

// ===== src/decimal_float_text_scanner_top.sv =====
// decimal number text scanner: sign, mantissa, exponent and end offset of a text
// depends on dfts_pkg for word types, phase codes and character constants
`default_nettype none

// Takes one character word per cycle, sustained while no result waits; the
// result word is registered from the ending character in the input register.
// Each character is resolved in one pass by the 64-bit times-ten add and limit
// compare of the mantissa, which together with the exponent saturation sets the
// cycle time. A result word is given when the scan ends at the first character
// that fits nowhere; a zero byte always ends a string, and first=1 restarts the
// scan at that character. While a result waits to be taken the held input word
// waits too, so the input stalls until the result is taken. The user must write
// radix only while the block is idle; the block itself does not enforce this.
module decimal_float_text_scanner_top
    import dfts_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEFAULT
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      radix_we,
    input  wire logic [7:0] radix,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire scan_in_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output scan_out_t      out_data
);

    localparam int EXT_BITS = POS_BITS + 16;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [7:0] dp_reg;

    scan_in_t in_word_reg;
    logic     in_valid_reg;
    scan_out_t out_word_reg;
    scan_out_t out_word_next;
    logic      out_valid_reg;

    phase_t              phase_reg, phase_next;
    logic                sign_reg, sign_next;
    logic [63:0]         mant_reg, mant_next;
    logic signed [31:0]  scale_reg, scale_next;
    logic [30:0]         edig_reg, edig_next;
    logic                eneg_reg, eneg_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] lpos_reg, lpos_next;

    logic advance;
    logic fire;
    logic emit;

    // values seen by the current character once a restart is applied
    phase_t              ph_cur;
    logic                sign_cur;
    logic [63:0]         mant_cur;
    logic signed [31:0]  scale_cur;
    logic [30:0]         edig_cur;
    logic                eneg_cur;
    logic [POS_BITS-1:0] pos_cur;
    logic [POS_BITS-1:0] lpos_cur;

    logic [7:0]  c;
    logic [3:0]  d;
    logic        is_digit, is_space, is_letter;
    logic        fits;
    logic [63:0] mant_mul;
    logic [34:0] edig_mul;
    logic [30:0] edig_sat;
    logic signed [32:0] exp_sum;
    logic signed [31:0] exp_sat;
    logic [POS_BITS-1:0] pos_inc;

    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_comb
    begin
        if (in_word_reg.first)
        begin
            ph_cur    = PH_WS;
            sign_cur  = 1'b0;
            mant_cur  = '0;
            scale_cur = '0;
            edig_cur  = '0;
            eneg_cur  = 1'b0;
            pos_cur   = '0;
            lpos_cur  = '0;
        end
        else
        begin
            ph_cur    = phase_reg;
            sign_cur  = sign_reg;
            mant_cur  = mant_reg;
            scale_cur = scale_reg;
            edig_cur  = edig_reg;
            eneg_cur  = eneg_reg;
            pos_cur   = pos_reg;
            lpos_cur  = lpos_reg;
        end
    end

    assign c         = in_word_reg.character;
    assign d         = c[3:0];
    assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    assign is_letter = (c == CH_LOW_E) || (c == CH_UP_E) || (c == CH_LOW_D) || (c == CH_UP_D);

    assign fits     = (mant_cur < MANT_LIMIT) || ((mant_cur == MANT_LIMIT) && (d <= MANT_LAST_DIGIT));
    assign mant_mul = {mant_cur[60:0], 3'b000} + {mant_cur[62:0], 1'b0} + {60'd0, d};

    assign edig_mul = {1'b0, edig_cur, 3'b000} + {3'b000, edig_cur, 1'b0} + {31'd0, d};
    assign edig_sat = (edig_mul > {4'd0, EXP_DIGITS_MAX}) ? EXP_DIGITS_MAX : edig_mul[30:0];

    assign exp_sum = {scale_cur[31], scale_cur}
                   + (eneg_cur ? -$signed({2'b00, edig_cur}) : $signed({2'b00, edig_cur}));
    // overflow when the two top bits disagree
    assign exp_sat = (exp_sum[32] != exp_sum[31]) ? (exp_sum[32] ? EXP_MIN : EXP_MAX)
                                                  : exp_sum[31:0];

    assign pos_inc = (pos_cur == POS_MAX) ? pos_cur : pos_cur + 1'b1;

    function automatic logic [15:0] to_offset(input logic [POS_BITS-1:0] p);
        logic [EXT_BITS-1:0] ext;
        begin
            ext = {16'd0, p};
            to_offset = (ext > {{POS_BITS{1'b0}}, OFFSET_MAX}) ? OFFSET_MAX : ext[15:0];
        end
    endfunction

    always_comb
    begin
        logic go_int, go_skip, go_point, go_frac, go_fskip, go_after, go_digits;
        logic nc;
        logic [POS_BITS-1:0] endpos;

        go_int    = 1'b0;
        go_skip   = 1'b0;
        go_point  = 1'b0;
        go_frac   = 1'b0;
        go_fskip  = 1'b0;
        go_after  = 1'b0;
        go_digits = 1'b0;
        nc        = 1'b0;
        endpos    = pos_cur;
        emit      = 1'b0;

        phase_next = ph_cur;
        sign_next  = sign_cur;
        mant_next  = mant_cur;
        scale_next = scale_cur;
        edig_next  = edig_cur;
        eneg_next  = eneg_cur;
        pos_next   = pos_cur;
        lpos_next  = lpos_cur;

        case (ph_cur)
            PH_WS:
            begin
                if (is_space)
                    pos_next = pos_inc;
                else if (c == CH_MINUS)
                begin
                    sign_next  = 1'b1;
                    pos_next   = pos_inc;
                    phase_next = PH_INT;
                end
                else if (c == CH_PLUS)
                begin
                    pos_next   = pos_inc;
                    phase_next = PH_INT;
                end
                else
                    go_int = 1'b1;
            end
            PH_INT:        go_int    = 1'b1;
            PH_INT_SKIP:   go_skip   = 1'b1;
            PH_FRAC:       go_frac   = 1'b1;
            PH_FRAC_SKIP:  go_fskip  = 1'b1;
            PH_EXP_DIGITS: go_digits = 1'b1;
            PH_EXP_LETTER:
            begin
                if (c == CH_MINUS)
                begin
                    eneg_next  = 1'b1;
                    pos_next   = pos_inc;
                    phase_next = PH_EXP_SIGNED;
                end
                else if (c == CH_PLUS)
                begin
                    pos_next   = pos_inc;
                    phase_next = PH_EXP_SIGNED;
                end
                else if (is_digit)
                    go_digits = 1'b1;
                else
                begin
                    emit   = 1'b1;
                    endpos = lpos_cur;
                end
            end
            PH_EXP_SIGNED:
            begin
                if (is_digit)
                    go_digits = 1'b1;
                else
                begin
                    emit   = 1'b1;
                    endpos = lpos_cur;
                end
            end
            default:
            begin
            end
        endcase

        if (go_int)
        begin
            if (is_digit)
            begin
                pos_next   = pos_inc;
                phase_next = PH_INT;
                if (fits)
                    mant_next = mant_mul;
                else
                begin
                    if (scale_cur != EXP_MAX)
                        scale_next = scale_cur + 32'sd1;
                    phase_next = PH_INT_SKIP;
                end
            end
            else
                go_point = 1'b1;
        end

        if (go_skip)
        begin
            if (is_digit)
            begin
                if (scale_cur != EXP_MAX)
                    scale_next = scale_cur + 32'sd1;
                pos_next = pos_inc;
            end
            else
                go_point = 1'b1;
        end

        if (go_point)
        begin
            // a zero byte never acts as the separator
            if ((c != CH_NUL) && (c == dp_reg))
            begin
                pos_next   = pos_inc;
                phase_next = PH_FRAC;
            end
            else
                go_after = 1'b1;
        end

        if (go_frac)
        begin
            if (is_digit)
            begin
                pos_next = pos_inc;
                if (fits)
                begin
                    mant_next = mant_mul;
                    if (scale_cur != EXP_MIN)
                        scale_next = scale_cur - 32'sd1;
                end
                else
                    phase_next = PH_FRAC_SKIP;
            end
            else
                go_after = 1'b1;
        end

        if (go_fskip)
        begin
            if (is_digit)
                pos_next = pos_inc;
            else
                go_after = 1'b1;
        end

        if (go_after)
        begin
            if (pos_cur == '0)
            begin
                emit = 1'b1;
                nc   = 1'b1;
            end
            else if (is_letter)
            begin
                lpos_next  = pos_cur;
                pos_next   = pos_inc;
                phase_next = PH_EXP_LETTER;
            end
            else
                emit = 1'b1;
        end

        if (go_digits)
        begin
            if (is_digit)
            begin
                edig_next  = edig_sat;
                pos_next   = pos_inc;
                phase_next = PH_EXP_DIGITS;
            end
            else
            begin
                scale_next = exp_sat;
                emit       = 1'b1;
            end
        end

        if (emit)
            phase_next = PH_IDLE;

        out_word_next.negative      = nc ? 1'b0 : sign_next;
        out_word_next.mantissa      = nc ? 64'd0 : mant_next;
        out_word_next.exponent      = nc ? 32'sd0 : scale_next;
        out_word_next.end_offset    = to_offset(endpos);
        out_word_next.no_conversion = nc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dp_reg <= RADIX_RESET;
        else if (radix_we)
            dp_reg <= radix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            sign_reg  <= 1'b0;
            mant_reg  <= '0;
            scale_reg <= '0;
            edig_reg  <= '0;
            eneg_reg  <= 1'b0;
            pos_reg   <= '0;
            lpos_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            sign_reg  <= sign_next;
            mant_reg  <= mant_next;
            scale_reg <= scale_next;
            edig_reg  <= edig_next;
            eneg_reg  <= eneg_next;
            pos_reg   <= pos_next;
            lpos_reg  <= lpos_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= fire && emit;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
            out_word_reg <= out_word_next;
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// self-checking bench for decimal_float_text_scanner_top: directed and random text
// needs dfts_pkg and the scanner rtl; prediction lives in the scoreboard class below
`timescale 1ns / 100ps

module tb
    import dfts_pkg::*;
();

    typedef enum logic [3:0] {
        SC_IDLE,
        SC_WS,
        SC_INT,
        SC_INT_SKIP,
        SC_POINT,
        SC_FRAC,
        SC_FRAC_SKIP,
        SC_AFTER,
        SC_EXP_LETTER,
        SC_EXP_SIGNED,
        SC_EXP_DIGITS
    } scan_state_t;

    class scan_scoreboard;
        scan_out_t          expected_q[$];
        int unsigned        failures;
        logic [7:0]         radix_char;
        scan_state_t        state;
        logic               neg;
        logic [63:0]        acc;
        logic signed [31:0] scale;
        int                 exp_val;
        logic               exp_neg;
        logic [15:0]        pos;
        logic [15:0]        letter_pos;

        function new();
            failures   = 0;
            radix_char = RADIX_RESET;
            state      = SC_IDLE;
            clear_scan();
        endfunction

        function void clear_scan();
            neg        = 1'b0;
            acc        = '0;
            scale      = '0;
            exp_val    = 0;
            exp_neg    = 1'b0;
            pos        = '0;
            letter_pos = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_letter(logic [7:0] c);
            return c == CH_LOW_E || c == CH_UP_E || c == CH_LOW_D || c == CH_UP_D;
        endfunction

        function void step_pos();
            if (pos != OFFSET_MAX)
                pos++;
        endfunction

        function bit digit_fits(logic [3:0] d);
            return !(acc > MANT_LIMIT || (acc == MANT_LIMIT && d > MANT_LAST_DIGIT));
        endfunction

        function void emit(logic [15:0] endpos, logic nc);
            scan_out_t r;
            r.negative      = nc ? 1'b0 : neg;
            r.mantissa      = nc ? '0 : acc;
            r.exponent      = nc ? '0 : scale;
            r.end_offset    = endpos;
            r.no_conversion = nc;
            expected_q.push_back(r);
            state = SC_IDLE;
        endfunction

        // runs one accepted word through the scan, queueing a result when it ends
        function void note_word(scan_in_t w);
            logic [7:0] c;
            logic [3:0] d;
            bit         settled;
            longint     wide;
            c       = w.character;
            d       = 4'(c - CH_ZERO);
            settled = 0;
            if (w.first)
            begin
                clear_scan();
                state = SC_WS;
            end
            while (!settled)
            begin
                case (state)
                    SC_WS:
                    begin
                        if (is_space(c))
                        begin
                            step_pos();
                            settled = 1;
                        end
                        else if (c == CH_MINUS || c == CH_PLUS)
                        begin
                            neg     = neg | (c == CH_MINUS);
                            step_pos();
                            state   = SC_INT;
                            settled = 1;
                        end
                        else
                            state = SC_INT;
                    end
                    SC_INT:
                    begin
                        if (is_digit(c))
                        begin
                            step_pos();
                            if (digit_fits(d))
                                acc = acc * 64'd10 + 64'(d);
                            else
                            begin
                                if (scale != EXP_MAX)
                                    scale++;
                                state = SC_INT_SKIP;
                            end
                            settled = 1;
                        end
                        else
                            state = SC_POINT;
                    end
                    SC_INT_SKIP:
                    begin
                        if (is_digit(c))
                        begin
                            if (scale != EXP_MAX)
                                scale++;
                            step_pos();
                            settled = 1;
                        end
                        else
                            state = SC_POINT;
                    end
                    SC_POINT:
                    begin
                        // a zero byte never stands for the radix
                        if (c != CH_NUL && c == radix_char)
                        begin
                            step_pos();
                            state   = SC_FRAC;
                            settled = 1;
                        end
                        else
                            state = SC_AFTER;
                    end
                    SC_FRAC:
                    begin
                        if (is_digit(c))
                        begin
                            step_pos();
                            if (digit_fits(d))
                            begin
                                acc = acc * 64'd10 + 64'(d);
                                if (scale != EXP_MIN)
                                    scale--;
                            end
                            else
                                state = SC_FRAC_SKIP;
                            settled = 1;
                        end
                        else
                            state = SC_AFTER;
                    end
                    SC_FRAC_SKIP:
                    begin
                        if (is_digit(c))
                        begin
                            step_pos();
                            settled = 1;
                        end
                        else
                            state = SC_AFTER;
                    end
                    SC_AFTER:
                    begin
                        settled = 1;
                        if (pos == 0)
                            emit('0, 1'b1);
                        else if (is_letter(c))
                        begin
                            letter_pos = pos;
                            step_pos();
                            state = SC_EXP_LETTER;
                        end
                        else
                            emit(pos, 1'b0);
                    end
                    SC_EXP_LETTER:
                    begin
                        if (c == CH_MINUS || c == CH_PLUS)
                        begin
                            exp_neg = (c == CH_MINUS);
                            step_pos();
                            state   = SC_EXP_SIGNED;
                            settled = 1;
                        end
                        else if (is_digit(c))
                            state = SC_EXP_DIGITS;
                        else
                        begin
                            // letter with no digits: the end backs up to the letter
                            emit(letter_pos, 1'b0);
                            settled = 1;
                        end
                    end
                    SC_EXP_SIGNED:
                    begin
                        if (is_digit(c))
                            state = SC_EXP_DIGITS;
                        else
                        begin
                            emit(letter_pos, 1'b0);
                            settled = 1;
                        end
                    end
                    SC_EXP_DIGITS:
                    begin
                        settled = 1;
                        if (is_digit(c))
                        begin
                            wide    = longint'(exp_val) * 10 + longint'(d);
                            exp_val = (wide > longint'(EXP_MAX)) ? int'(EXP_MAX) : int'(wide);
                            step_pos();
                        end
                        else
                        begin
                            wide = longint'(scale) +
                                   (exp_neg ? -longint'(exp_val) : longint'(exp_val));
                            if (wide > longint'(EXP_MAX))
                                wide = longint'(EXP_MAX);
                            if (wide < longint'(EXP_MIN))
                                wide = longint'(EXP_MIN);
                            scale = 32'(wide);
                            emit(pos, 1'b0);
                        end
                    end
                    default:
                        settled = 1;
                endcase
            end
        endfunction

        function void check_result(scan_out_t got);
            scan_out_t want;
            bit        bad;
            if (expected_q.size() == 0)
            begin
                if (failures < 10)
                    $display("scan error: unexpected result neg=%0b mant=%0d exp=%0d end=%0d nc=%0b",
                             got.negative, got.mantissa, got.exponent, got.end_offset,
                             got.no_conversion);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            bad  = (got.negative !== want.negative) || (got.mantissa !== want.mantissa) ||
                   (got.exponent !== want.exponent) || (got.end_offset !== want.end_offset) ||
                   (got.no_conversion !== want.no_conversion);
            if (bad)
            begin
                if (failures < 10)
                begin
                    $display("scan error: expected neg=%0b mant=%0d exp=%0d end=%0d nc=%0b",
                             want.negative, want.mantissa, want.exponent, want.end_offset,
                             want.no_conversion);
                    $display("            actual   neg=%0b mant=%0d exp=%0d end=%0d nc=%0b",
                             got.negative, got.mantissa, got.exponent, got.end_offset,
                             got.no_conversion);
                end
                failures++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      radix_we;
    logic [7:0] radix;
    logic      in_valid;
    logic      in_ready;
    scan_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    scan_out_t out_data;

    scan_scoreboard sb;
    logic [7:0]     text_q[$];
    int             item_count = 0;
    int             send_burst = 0;
    int             take_burst = 0;

    decimal_float_text_scanner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix_we  (radix_we),
        .radix     (radix),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #6 clk = ~clk;

    // draws a random wait, with the odd run of back-to-back words
    function automatic int draw_wait(ref int burst);
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic void push_word(string s);
        foreach (s[i])
            text_q.push_back(s[i]);
    endfunction

    // mostly short digit runs, some long enough to overflow, some at the limit
    function automatic void push_mantissa_digits();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        if (pick == 9)
        begin
            push_word("1844674407370955161");
            n = $urandom_range(1, 3);
        end
        else if (pick >= 7)
            n = $urandom_range(17, 24);
        else
            n = $urandom_range(0, 5);
        repeat (n)
            text_q.push_back(any_digit());
    endfunction

    function automatic void push_exponent_digits();
        int pick;
        int n;
        pick = $urandom_range(0, 9);
        n    = 0;
        if (pick == 1)
        begin
            push_word("2147483647");
            n = $urandom_range(0, 1);
        end
        else if (pick == 2)
            push_word("2147483648");
        else if (pick == 3)
            n = $urandom_range(10, 12);
        else if (pick != 0)
            n = $urandom_range(1, 3);
        repeat (n)
            text_q.push_back(any_digit());
    endfunction

    function automatic void make_text(logic [7:0] radix_code);
        int n;
        int pick;
        text_q.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                pick = $urandom_range(0, 5);
                text_q.push_back(pick == 5 ? CH_SPACE : CH_TAB + 8'(pick));
            end
        end
        pick = $urandom_range(0, 2);
        if (pick == 1)
            text_q.push_back(CH_MINUS);
        else if (pick == 2)
            text_q.push_back(CH_PLUS);
        push_mantissa_digits();
        if ($urandom_range(0, 4) != 0)
        begin
            text_q.push_back(radix_code);
            push_mantissa_digits();
        end
        if ($urandom_range(0, 2) != 0)
        begin
            case ($urandom_range(0, 3))
                0: text_q.push_back(CH_LOW_E);
                1: text_q.push_back(CH_UP_E);
                2: text_q.push_back(CH_LOW_D);
                default: text_q.push_back(CH_UP_D);
            endcase
            pick = $urandom_range(0, 2);
            if (pick == 1)
                text_q.push_back(CH_MINUS);
            else if (pick == 2)
                text_q.push_back(CH_PLUS);
            push_exponent_digits();
        end
        text_q.push_back($urandom_range(0, 3) == 0 ? CH_NUL : 8'($urandom_range(0, 255)));
    endfunction

    task automatic send_word(logic [7:0] ch, logic fst);
        int       gap;
        scan_in_t w;
        w.character = ch;
        w.first     = fst;
        gap = draw_wait(send_burst);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_word(w);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_word(text_q[i], i == 0);
        item_count += text_q.size();
    endtask

    // close any open string, let the block drain, then change the radix
    task automatic write_radix(logic [7:0] v);
        send_word(CH_NUL, 1'b0);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        radix_we <= 1'b1;
        radix    <= v;
        @(posedge clk);
        radix_we <= 1'b0;
        sb.radix_char = v;
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait(take_burst);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(out_data);
        end
    end

    initial
    begin
        #5_000_000;
        $display("decimal_float_text_scanner_top: mismatch");
        $finish;
    end

    initial
    begin
        logic [7:0] radix_plan[7];
        clk      = 1'b0;
        rst_n    = 1'b0;
        radix_we = 1'b0;
        radix    = RADIX_RESET;
        in_valid = 1'b0;
        in_data  = '0;
        sb       = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings with the reset radix
        text_q = '{CH_NUL};
        send_text();
        send_word(8'hFF, 1'b0);
        text_q = '{"x"};
        send_text();
        text_q = '{CH_SPACE, CH_TAB, CH_MINUS, CH_NUL};
        send_text();
        text_q = '{"1", CH_LOW_E, CH_PLUS, CH_NUL};
        send_text();
        text_q = '{"9", ".", "5", CH_UP_D, CH_MINUS, "7", 8'hFF};
        send_text();
        text_q = '{CH_CR, CH_PLUS, "0", CH_UP_E, "3", CH_NUL};
        send_text();

        // radix extremes, a comma, a digit, a blank, back to the usual one, then a random code
        radix_plan = '{8'hFF, 8'h00, 8'h2C, 8'h35, 8'h20, 8'h2E, 8'($urandom_range(0, 255))};
        foreach (radix_plan[p])
        begin
            write_radix(radix_plan[p]);
            while (item_count < 25 + (p + 1) * 150)
            begin
                make_text(radix_plan[p]);
                send_text();
                // stray word after a string, usually ignored
                if ($urandom_range(0, 7) == 0)
                    send_word(8'($urandom_range(0, 255)), 1'b0);
            end
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0)
            $display("decimal_float_text_scanner_top: match");
        else
            $display("decimal_float_text_scanner_top: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dfts_pkg.sv
src/decimal_float_text_scanner_top.sv
dv/tb.sv
